[src/lss_pkg.sv]
package lss_pkg;

  // Operation codes carried in the mode field of a request.
  localparam logic [2:0] OpPush   = 3'd0;
  localparam logic [2:0] OpPop    = 3'd1;
  localparam logic [2:0] OpSearch = 3'd2;
  localparam logic [2:0] OpCount  = 3'd3;
  localparam logic [2:0] OpClear  = 3'd4;

  // Error codes reported with every result.
  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrUnderflow = 2'd1;
  localparam logic [1:0] ErrOverflow  = 2'd2;

  // Word reported when there is nothing to report.
  localparam logic signed [31:0] NoWord = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } lss_in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] top_value;
    logic [4:0]         fill_level;
    logic               is_empty;
    logic               is_full;
    logic               found;
    logic [4:0]         match_count;
    logic [1:0]         error_code;
  } lss_out_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
    logic load;
    logic shift;
  } lss_ctrl_t;

endpackage

[src/lss_cell.sv]
module lss_cell
  import lss_pkg::*;
(
  input  logic               clk_i,
  input  lss_ctrl_t          ctrl_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] up_word_i,
  input  logic signed [31:0] dn_word_i,
  input  logic               dn_match_i,
  output logic signed [31:0] word_o,
  output logic               match_o
);

  logic signed [31:0] word_q, word_d;
  logic               match_q, match_d;

  // A push takes the word from the cell above, a pop the word from the cell below.
  always_comb begin
    priority if (ctrl_i.push) begin
      word_d = up_word_i;
    end else if (ctrl_i.pop) begin
      word_d = dn_word_i;
    end else begin
      word_d = word_q;
    end
  end

  // The match bit is set by the local comparator, then walks toward the top.
  always_comb begin
    priority if (ctrl_i.load) begin
      match_d = (word_q == key_i);
    end else if (ctrl_i.shift) begin
      match_d = dn_match_i;
    end else begin
      match_d = match_q;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    match_q <= match_d;
  end

  assign word_o  = word_q;
  assign match_o = match_q;

endmodule

[src/lifo_stack_with_search_count.sv]
// A bounded last-in-first-out stack of signed 32-bit words, DEPTH entries deep,
// built as a chain of cells with the top of the stack in cell 0. Each request
// carries an operation (push, pop, search, count or clear) and a value, and
// yields exactly one result that reports the popped word, the top word, the
// fill level and the empty and full flags as they stand after the operation.
// Push, pop, clear and the unused mode codes write their result in the cycle
// they are accepted; a push or pop that does not overflow or underflow shifts
// the whole chain by one cell in that cycle. For search and count, every cell
// compares its word in the accept cycle, then the match bits walk up the chain
// one cell per cycle into a single counter at the top, once per stored word,
// and the result is written once the output register is free. A new request
// is taken only when no scan runs and the output register is empty or its
// result leaves in the same cycle, so a stalled result holds the input off.
module lifo_stack_with_search_count
  import lss_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lss_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lss_out_t out_data_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FullLevel = CW'(DEPTH);

  typedef enum logic {
    Idle,
    Scan
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] remain_q, remain_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          search_q, search_d;
  logic          out_valid_q, out_valid_d;
  lss_out_t      out_data_q, out_data_d;

  lss_ctrl_t          ctrl;
  logic signed [31:0] cell_word  [DEPTH];
  logic               cell_match [DEPTH];

  logic accept;
  logic out_free;

  // The chain: cell 0 holds the top word. Pushes move words down the chain,
  // pops move them up, and match bits always travel upward.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] up_word;
    logic signed [31:0] dn_word;
    logic               dn_match;

    if (i == 0) begin : g_top
      assign up_word = in_data_i.value;
    end else begin : g_mid
      assign up_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign dn_word  = cell_word[i];
      assign dn_match = 1'b0;
    end else begin : g_inner
      assign dn_word  = cell_word[i+1];
      assign dn_match = cell_match[i+1];
    end

    lss_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .key_i      (in_data_i.value),
      .up_word_i  (up_word),
      .dn_word_i  (dn_word),
      .dn_match_i (dn_match),
      .word_o     (cell_word[i]),
      .match_o    (cell_match[i])
    );
  end

  // The output register is free when it is empty or being taken this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != Idle) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    remain_d    = remain_q;
    cnt_d       = cnt_q;
    search_d    = search_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ctrl        = '0;

    unique case (state_q)
      Idle: begin
        if (accept) begin
          // Defaults for a result written in the accept cycle.
          out_data_d.popped_value = NoWord;
          out_data_d.top_value    = (fill_q == '0) ? NoWord : cell_word[0];
          out_data_d.found        = 1'b0;
          out_data_d.match_count  = '0;
          out_data_d.error_code   = ErrNone;
          out_valid_d             = 1'b1;

          unique case (in_data_i.mode)
            OpPush: begin
              if (fill_q == FullLevel) begin
                out_data_d.error_code = ErrOverflow;
              end else begin
                ctrl.push            = 1'b1;
                fill_d               = fill_q + CW'(1);
                out_data_d.top_value = in_data_i.value;
              end
            end
            OpPop: begin
              if (fill_q == '0) begin
                out_data_d.error_code = ErrUnderflow;
              end else begin
                ctrl.pop                = 1'b1;
                fill_d                  = fill_q - CW'(1);
                out_data_d.popped_value = cell_word[0];
                out_data_d.top_value    = (fill_q == CW'(1)) ? NoWord : cell_word[1];
              end
            end
            OpSearch, OpCount: begin
              // Every cell compares at once; the result comes after the scan.
              ctrl.load   = 1'b1;
              remain_d    = fill_q;
              cnt_d       = '0;
              search_d    = (in_data_i.mode == OpSearch);
              state_d     = Scan;
              out_valid_d = out_valid_q && out_stall_i;
              out_data_d  = out_data_q;
            end
            OpClear: begin
              fill_d               = '0;
              out_data_d.top_value = NoWord;
            end
            default: begin
              // Unused codes leave the stack as it is and report its status.
            end
          endcase

          if (state_d == Idle) begin
            out_data_d.fill_level = 5'(fill_d);
            out_data_d.is_empty   = (fill_d == '0);
            out_data_d.is_full    = (fill_d == FullLevel);
          end
        end
      end

      Scan: begin
        if (remain_q != '0) begin
          // Count the bit at the top and move the next one up.
          cnt_d      = cnt_q + CW'(cell_match[0]);
          ctrl.shift = 1'b1;
          remain_d   = remain_q - CW'(1);
        end else if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.popped_value = NoWord;
          out_data_d.top_value    = (fill_q == '0) ? NoWord : cell_word[0];
          out_data_d.fill_level   = 5'(fill_q);
          out_data_d.is_empty     = (fill_q == '0);
          out_data_d.is_full      = (fill_q == FullLevel);
          out_data_d.found        = search_q && (cnt_q != '0);
          out_data_d.match_count  = search_q ? 5'd0 : 5'(cnt_q);
          out_data_d.error_code   = ErrNone;
          state_d                 = Idle;
        end
      end

      default: begin
        state_d = Idle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      fill_q      <= '0;
      remain_q    <= '0;
      cnt_q       <= '0;
      search_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      remain_q    <= remain_d;
      cnt_q       <= cnt_d;
      search_q    <= search_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
